[sv/hcr_pkg.sv]
package hcr_pkg;

  localparam int HEIGHT_BITS = 16;
  localparam int SPAN_W      = HEIGHT_BITS + 1;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int IN_TDATA_W  = ((HEIGHT_BITS + 7) / 8) * 8;
  localparam int NUM_CH      = 3;
  localparam int CH_W        = 8;
  localparam int OUT_TDATA_W = NUM_CH * CH_W;
  localparam int QUO_W       = 8;
  localparam int DIV_STAGES  = QUO_W;
  localparam int PROD_W      = HEIGHT_BITS + CH_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int SETTLE_CYCLES = 5;
  localparam int SETTLE_W    = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_TOP_HEIGHT   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_OCEAN_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    SEG_SAND,
    SEG_PLAIN,
    SEG_HIGH_PLAIN,
    SEG_LOW_MOUNTAIN,
    SEG_ROCK,
    SEG_SNOW,
    SEG_BEYOND
  } seg_t;

  // Segment boundaries and lengths derived from the configured heights.
  typedef struct packed {
    logic                   ready;
    logic [SPAN_W-1:0]      span;
    logic [SPAN_W-1:0]      b1;
    logic [SPAN_W-1:0]      b2;
    logic [SPAN_W-1:0]      b3;
    logic [SPAN_W-1:0]      b4;
    logic [SPAN_W-1:0]      b5;
    logic [HEIGHT_BITS-1:0] len10;
    logic [HEIGHT_BITS-1:0] len2;
    logic [HEIGHT_BITS-1:0] len5;
  } ramp_bounds_t;

  typedef struct packed {
    seg_t                   seg;
    logic [HEIGHT_BITS-1:0] offset;
    logic [HEIGHT_BITS-1:0] len;
  } ramp_item_t;

  // Start color of a segment, blue in the top byte, red in the bottom byte.
  function automatic logic [OUT_TDATA_W-1:0] seg_start(seg_t s);
    logic [OUT_TDATA_W-1:0] c;
    case (s)
      SEG_SAND:         c = {8'd36,  8'd178, 8'd228};
      SEG_PLAIN:        c = {8'd80,  8'd208, 8'd146};
      SEG_HIGH_PLAIN:   c = {8'd29,  8'd122, 8'd24};
      SEG_LOW_MOUNTAIN: c = {8'd7,   8'd39,  8'd66};
      SEG_ROCK:         c = {8'd125, 8'd125, 8'd125};
      default:          c = {8'd255, 8'd255, 8'd255};
    endcase
    return c;
  endfunction

  // Magnitude of the color change over a segment, per channel.
  function automatic logic [OUT_TDATA_W-1:0] seg_step_mag(seg_t s);
    logic [OUT_TDATA_W-1:0] c;
    case (s)
      SEG_SAND:         c = {8'd44,  8'd30,  8'd82};
      SEG_PLAIN:        c = {8'd51,  8'd86,  8'd122};
      SEG_HIGH_PLAIN:   c = {8'd22,  8'd83,  8'd42};
      SEG_LOW_MOUNTAIN: c = {8'd118, 8'd86,  8'd59};
      SEG_ROCK:         c = {8'd130, 8'd130, 8'd130};
      default:          c = '0;
    endcase
    return c;
  endfunction

  // Set where the channel falls over the segment; bit 0 is red.
  function automatic logic [NUM_CH-1:0] seg_step_neg(seg_t s);
    logic [NUM_CH-1:0] n;
    case (s)
      SEG_SAND:       n = 3'b001;
      SEG_PLAIN:      n = 3'b111;
      SEG_HIGH_PLAIN: n = 3'b110;
      default:        n = 3'b000;
    endcase
    return n;
  endfunction

endpackage

[sv/hcr_bounds.sv]
module hcr_bounds
  import hcr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output ramp_bounds_t           bounds
);

  localparam int DIV10_SHIFT = HEIGHT_BITS + 4;
  localparam logic [SPAN_W-1:0] DIV10_MAGIC = SPAN_W'((64'd1 << DIV10_SHIFT) / 64'd10);
  localparam int Q10_W = HEIGHT_BITS - 2;
  localparam logic [SPAN_W-1:0] TEN = SPAN_W'(10);

  logic [CFG_DATA_W-1:0]  top_height;
  logic [CFG_DATA_W-1:0]  ocean_height;
  logic [SETTLE_W-1:0]    settle;

  logic [SPAN_W-1:0]      span_a;
  logic [2*SPAN_W-1:0]    prod_b;
  logic [SPAN_W-1:0]      span_b;
  logic [SPAN_W-1:0]      span_c;
  logic [HEIGHT_BITS-1:0] len10_c, len2_c, len5_c;
  logic [SPAN_W-1:0]      span_d, b2_d, b3_d, t15_d;
  logic [HEIGHT_BITS-1:0] len10_d, len2_d, len5_d;
  logic [SPAN_W-1:0]      span_e, b2_e, b3_e, b4_e, b5_e;
  logic [HEIGHT_BITS-1:0] len10_e, len2_e, len5_e;

  logic [HEIGHT_BITS-1:0] t_h, o_h;
  logic [Q10_W-1:0]       q0;
  logic [SPAN_W-1:0]      r_full;
  logic [4:0]             r5;
  logic [4:0]             rr;
  logic [HEIGHT_BITS-1:0] len10_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_height   <= CFG_DATA_W'(255);
      ocean_height <= '0;
      settle       <= SETTLE_W'(SETTLE_CYCLES);
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TOP_HEIGHT:   top_height   <= cfg_data;
          REG_OCEAN_HEIGHT: ocean_height <= cfg_data;
          default: ;
        endcase
        settle <= SETTLE_W'(SETTLE_CYCLES);
      end else if (settle != '0) begin
        settle <= settle - SETTLE_W'(1);
      end
    end
  end

  assign t_h = HEIGHT_BITS'(top_height);
  assign o_h = HEIGHT_BITS'(ocean_height);

  // Remainder after the reciprocal estimate is below twenty, so one
  // correction step gives the exact tenth.
  always_comb begin
    q0     = prod_b[DIV10_SHIFT +: Q10_W];
    r_full = span_b - SPAN_W'(q0) * TEN;
    r5     = r_full[4:0];
    if (r5 >= 5'd10) begin
      len10_next = HEIGHT_BITS'(q0) + HEIGHT_BITS'(1);
      rr         = r5 - 5'd10;
    end else begin
      len10_next = HEIGHT_BITS'(q0);
      rr         = r5;
    end
  end

  always_ff @(posedge clk) begin
    span_a  <= (t_h < o_h) ? SPAN_W'(1) : SPAN_W'(t_h) - SPAN_W'(o_h) + SPAN_W'(1);

    prod_b  <= (2*SPAN_W)'(span_a) * (2*SPAN_W)'(DIV10_MAGIC);
    span_b  <= span_a;

    span_c  <= span_b;
    len10_c <= len10_next;
    len2_c  <= span_b[SPAN_W-1:1];
    len5_c  <= {len10_next[HEIGHT_BITS-2:0], 1'b0} + HEIGHT_BITS'(rr >= 5'd5);

    span_d  <= span_c;
    b2_d    <= SPAN_W'({len10_c, 1'b0});
    b3_d    <= SPAN_W'({len10_c, 1'b0}) + SPAN_W'(len2_c);
    t15_d   <= SPAN_W'(len10_c) + SPAN_W'(len5_c);
    len10_d <= len10_c;
    len2_d  <= len2_c;
    len5_d  <= len5_c;

    span_e  <= span_d;
    b2_e    <= b2_d;
    b3_e    <= b3_d;
    b4_e    <= b3_d + SPAN_W'(len10_d);
    b5_e    <= b3_d + t15_d;
    len10_e <= len10_d;
    len2_e  <= len2_d;
    len5_e  <= len5_d;
  end

  always_comb begin
    bounds.ready = (settle == '0);
    bounds.span  = span_e;
    bounds.b1    = SPAN_W'(len10_e);
    bounds.b2    = b2_e;
    bounds.b3    = b3_e;
    bounds.b4    = b4_e;
    bounds.b5    = b5_e;
    bounds.len10 = len10_e;
    bounds.len2  = len2_e;
    bounds.len5  = len5_e;
  end

endmodule

[sv/hcr_front.sv]
module hcr_front
  import hcr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  ramp_bounds_t          bounds,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,
  input  logic                  queue_full,
  output logic                  push,
  output ramp_item_t            push_item
);

  logic       f_valid;
  ramp_item_t f_item;
  ramp_item_t cls;
  logic       advance;
  logic [SPAN_W-1:0] idx;

  assign advance       = !f_valid || !queue_full;
  assign s_axis_tready = bounds.ready && advance;
  assign push          = f_valid && !queue_full;
  assign push_item     = f_item;

  // Boundaries rise monotonically, so an empty segment never matches.
  always_comb begin
    idx = SPAN_W'(s_axis_tdata[HEIGHT_BITS-1:0]);
    cls.seg    = SEG_SNOW;
    cls.offset = '0;
    cls.len    = HEIGHT_BITS'(1);
    if (idx > bounds.span) begin
      cls.seg = SEG_BEYOND;
    end else if (idx < bounds.b1) begin
      cls.seg    = SEG_SAND;
      cls.offset = HEIGHT_BITS'(idx);
      cls.len    = bounds.len10;
    end else if (idx < bounds.b2) begin
      cls.seg    = SEG_PLAIN;
      cls.offset = HEIGHT_BITS'(idx - bounds.b1);
      cls.len    = bounds.len10;
    end else if (idx < bounds.b3) begin
      cls.seg    = SEG_HIGH_PLAIN;
      cls.offset = HEIGHT_BITS'(idx - bounds.b2);
      cls.len    = bounds.len2;
    end else if (idx < bounds.b4) begin
      cls.seg    = SEG_LOW_MOUNTAIN;
      cls.offset = HEIGHT_BITS'(idx - bounds.b3);
      cls.len    = bounds.len10;
    end else if (idx < bounds.b5) begin
      cls.seg    = SEG_ROCK;
      cls.offset = HEIGHT_BITS'(idx - bounds.b4);
      cls.len    = bounds.len5;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (advance) begin
      f_valid <= s_axis_tvalid && bounds.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      f_item <= cls;
    end
  end

endmodule

[sv/hcr_queue.sv]
module hcr_queue
  import hcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  ramp_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       valid,
  output ramp_item_t item
);

  ramp_item_t          mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full  = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (QUEUE_AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QUEUE_AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> valid)
    else $error("pop from an empty queue");

endmodule

[sv/hcr_back.sv]
module hcr_back
  import hcr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   queue_valid,
  input  ramp_item_t             queue_item,
  output logic                   pop,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [0:0]             m_axis_tuser
);

  logic                   en;
  logic                   v     [DIV_STAGES+1];
  seg_t                   seg_a [DIV_STAGES+1];
  logic [HEIGHT_BITS-1:0] len_a [DIV_STAGES+1];
  logic [PROD_W-1:0]      rem_a [DIV_STAGES+1][NUM_CH];
  logic [QUO_W-1:0]       quo_a [DIV_STAGES+1][NUM_CH];

  logic [PROD_W-1:0]      rem_n [DIV_STAGES+1][NUM_CH];
  logic [QUO_W-1:0]       quo_n [DIV_STAGES+1][NUM_CH];
  logic [OUT_TDATA_W-1:0] mag;
  logic [OUT_TDATA_W-1:0] color;
  logic [OUT_TDATA_W-1:0] start;
  logic [NUM_CH-1:0]      neg;

  // The whole pipeline holds while a finished beat waits at the output.
  assign en  = !m_axis_tvalid || m_axis_tready;
  assign pop = en && queue_valid;
  assign mag = seg_step_mag(queue_item.seg);

  // One restoring step per stage, quotient MSB first.
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      rem_n[0][c] = '0;
      quo_n[0][c] = '0;
    end
    for (int s = 1; s <= DIV_STAGES; s++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        rem_n[s][c] = rem_a[s-1][c];
        quo_n[s][c] = quo_a[s-1][c];
        if (rem_a[s-1][c] >= (PROD_W'(len_a[s-1]) << (DIV_STAGES - s))) begin
          rem_n[s][c] = rem_a[s-1][c] - (PROD_W'(len_a[s-1]) << (DIV_STAGES - s));
          quo_n[s][c][DIV_STAGES - s] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= DIV_STAGES; s++) begin
        v[s] <= 1'b0;
      end
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      v[0] <= pop;
      for (int s = 1; s <= DIV_STAGES; s++) begin
        v[s] <= v[s-1];
      end
      m_axis_tvalid <= v[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seg_a[0] <= queue_item.seg;
      len_a[0] <= queue_item.len;
      for (int c = 0; c < NUM_CH; c++) begin
        rem_a[0][c] <= PROD_W'(queue_item.offset) * PROD_W'(mag[c*CH_W +: CH_W]);
        quo_a[0][c] <= quo_n[0][c];
      end
      for (int s = 1; s <= DIV_STAGES; s++) begin
        seg_a[s] <= seg_a[s-1];
        len_a[s] <= len_a[s-1];
        for (int c = 0; c < NUM_CH; c++) begin
          rem_a[s][c] <= rem_n[s][c];
          quo_a[s][c] <= quo_n[s][c];
        end
      end
    end
  end

  // The interpolated value always lies between the two end colors.
  always_comb begin
    start = seg_start(seg_a[DIV_STAGES]);
    neg   = seg_step_neg(seg_a[DIV_STAGES]);
    for (int c = 0; c < NUM_CH; c++) begin
      if (neg[c]) begin
        color[c*CH_W +: CH_W] = start[c*CH_W +: CH_W] - quo_a[DIV_STAGES][c];
      end else begin
        color[c*CH_W +: CH_W] = start[c*CH_W +: CH_W] + quo_a[DIV_STAGES][c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata    <= color;
      m_axis_tuser[0] <= (seg_a[DIV_STAGES] == SEG_BEYOND);
    end
  end

endmodule

[sv/height_color_ramp.sv]
// An accepted input beat passes through the classify register, the queue, the
// product stage, 8 divider stages and the output register. Throughput: one beat
// per cycle unless output back-pressure or a configuration write stalls it; the queue holds 4 items.
// A configuration write holds s_axis_tready low while the segment boundaries
// are recomputed. Reset is synchronous, active high, restores top_height 255
// and ocean_height 0, and holds s_axis_tready low in the same way.
module height_color_ramp
  import hcr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // height_index
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // red, green, blue
  output logic [0:0]             m_axis_tuser    // beyond_span
);

  ramp_bounds_t bounds;
  logic         queue_full;
  logic         push;
  ramp_item_t   push_item;
  logic         pop;
  logic         queue_valid;
  ramp_item_t   queue_item;

  hcr_bounds u_bounds (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .bounds    (bounds)
  );

  hcr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .bounds        (bounds),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .queue_full    (queue_full),
    .push          (push),
    .push_item     (push_item)
  );

  hcr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .valid     (queue_valid),
    .item      (queue_item)
  );

  hcr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .queue_valid   (queue_valid),
    .queue_item    (queue_item),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !s_axis_tready)
    else $error("input accepted while boundaries are being recomputed");

  a_beyond_is_white: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == {OUT_TDATA_W{1'b1}}))
    else $error("beyond-span beat is not white");

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
  import hcr_pkg::*;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            beyond;
  } ramp_color_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // height_index
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // red, green, blue
  logic [0:0]             m_axis_tuser;   // beyond_span

  height_color_ramp dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Local copy of the configured heights.
  logic [15:0] top_h;
  logic [15:0] ocean_h;

  ramp_color_t expected_colors[$];

  int src_gap_max;
  int sink_gap_max;
  int sink_hold;
  int heights_sent;
  int colors_checked;
  int ramps_tried;
  int mismatches;
  int unexpected;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("Timeout: %0d heights sent, %0d colors checked", heights_sent, colors_checked);
    $display("RESULT: ERROR");
    $finish;
  end

  // Color at a knot of the ramp, red in the low byte.
  function automatic logic [OUT_TDATA_W-1:0] knot_rgb(int k);
    logic [OUT_TDATA_W-1:0] rgb;
    case (seg_t'(k))
      SEG_SAND:         rgb = {8'd36, 8'd178, 8'd228};
      SEG_PLAIN:        rgb = {8'd80, 8'd208, 8'd146};
      SEG_HIGH_PLAIN:   rgb = {8'd29, 8'd122, 8'd24};
      SEG_LOW_MOUNTAIN: rgb = {8'd7, 8'd39, 8'd66};
      SEG_ROCK:         rgb = {8'd125, 8'd125, 8'd125};
      default:          rgb = {8'd255, 8'd255, 8'd255};
    endcase
    return rgb;
  endfunction

  function automatic logic [16:0] ramp_span();
    if (top_h < ocean_h) return 17'd1;
    return {1'b0, top_h} - {1'b0, ocean_h} + 17'd1;
  endfunction

  function automatic ramp_color_t ramp_color(logic [15:0] height);
    logic [16:0] span;
    logic [16:0] seg_len [5];
    logic [16:0] base;
    logic [OUT_TDATA_W-1:0] from_rgb;
    logic [OUT_TDATA_W-1:0] to_rgb;
    logic [CH_W-1:0] chan [3];
    longint j;
    longint l;
    longint s;
    longint e;
    longint v;
    ramp_color_t c;
    c.red    = 8'hFF;
    c.green  = 8'hFF;
    c.blue   = 8'hFF;
    c.beyond = 1'b0;
    span = ramp_span();
    if ({1'b0, height} > span) begin
      c.beyond = 1'b1;
      return c;
    end
    seg_len[0] = 17'(span / 10);
    seg_len[1] = 17'(span / 10);
    seg_len[2] = 17'(span / 2);
    seg_len[3] = 17'(span / 10);
    seg_len[4] = 17'(span / 5);
    base = '0;
    for (int k = 0; k < 5; k++) begin
      // Empty segments fall through without moving the base.
      if (seg_len[k] != 0 && {1'b0, height} >= base &&
          {1'b0, height} - base < seg_len[k]) begin
        j = longint'({1'b0, height} - base);
        l = longint'(seg_len[k]);
        from_rgb = knot_rgb(k);
        to_rgb = knot_rgb(k + 1);
        for (int ch = 0; ch < 3; ch++) begin
          s = longint'(from_rgb[ch*8 +: 8]);
          e = longint'(to_rgb[ch*8 +: 8]);
          v = s + (j * (e - s)) / l;
          if (v < 0) v = 0;
          if (v > 255) v = 255;
          chan[ch] = v[7:0];
        end
        c.red   = chan[0];
        c.green = chan[1];
        c.blue  = chan[2];
        return c;
      end
      base = base + seg_len[k];
    end
    return c;
  endfunction

  // Sink side: after every beat taken, hold tready low for a random count.
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (sink_hold > 0) begin
      m_axis_tready <= 1'b0;
      sink_hold = sink_hold - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    ramp_color_t got;
    ramp_color_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.red    = m_axis_tdata[7:0];
      got.green  = m_axis_tdata[15:8];
      got.blue   = m_axis_tdata[23:16];
      got.beyond = m_axis_tuser[0];
      sink_hold = $urandom_range(0, sink_gap_max);
      if (expected_colors.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("Unexpected beat at %0t: rgb %0d,%0d,%0d beyond %0d", $realtime,
                   got.red, got.green, got.blue, got.beyond);
      end else begin
        want = expected_colors.pop_front();
        colors_checked++;
        if (got.red !== want.red || got.green !== want.green ||
            got.blue !== want.blue || got.beyond !== want.beyond) begin
          mismatches++;
          if (mismatches + unexpected <= 10)
            $display("Mismatch at %0t: expected rgb %0d,%0d,%0d beyond %0d, got %0d,%0d,%0d beyond %0d",
                     $realtime, want.red, want.green, want.blue, want.beyond,
                     got.red, got.green, got.blue, got.beyond);
        end
      end
    end
  end

  task automatic send_height(logic [15:0] height);
    int gap;
    ramp_color_t want;
    gap = $urandom_range(0, src_gap_max);
    want = ramp_color(height);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= height;
    do @(posedge clk); while (!s_axis_tready);
    expected_colors.insert(expected_colors.size(), want);
    heights_sent++;
  endtask

  // Drops tvalid and waits until every expected color has come out.
  task automatic drain_colors();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (index == REG_TOP_HEIGHT) top_h = value;
    else ocean_h = value;
  endtask

  task automatic set_ramp(logic [15:0] top, logic [15:0] ocean);
    drain_colors();
    write_reg(REG_TOP_HEIGHT, top);
    write_reg(REG_OCEAN_HEIGHT, ocean);
    ramps_tried++;
  endtask

  // Reset ramp has a span of 256: segment starts at 0, 25, 50, 178 and 203,
  // snow from 254.
  task automatic test_reset_ramp();
    src_gap_max  = 0;
    sink_gap_max = 0;
    send_height(16'd0);
    send_height(16'd24);
    send_height(16'd25);
    send_height(16'd50);
    send_height(16'd178);
    send_height(16'd203);
    send_height(16'd254);
    send_height(16'd256);
    send_height(16'd257);
    send_height(16'hFFFF);
  endtask

  task automatic test_config_extremes();
    // Widest span: 65536, so no index can go beyond it.
    set_ramp(16'hFFFF, 16'h0000);
    send_height(16'd6553);
    send_height(16'd32767);
    send_height(16'd65533);
    send_height(16'hFFFF);
    // Top below ocean: span saturates to one.
    set_ramp(16'h0000, 16'hFFFF);
    send_height(16'd0);
    send_height(16'd1);
    send_height(16'd2);
    // Span of nine leaves sand, plain and low mountain empty.
    set_ramp(16'd8, 16'd0);
    send_height(16'd3);
    send_height(16'd4);
    send_height(16'd10);
  endtask

  task automatic test_random_ramps(int phases, int per_phase);
    int mode;
    int ocean;
    int top;
    int span_i;
    int pick;
    int height;
    for (int p = 0; p < phases; p++) begin
      mode = $urandom_range(0, 4);
      ocean = $urandom_range(0, 65535);
      case (mode)
        0: top = ocean + $urandom_range(0, 60);
        1: top = $urandom_range(0, 65535);
        2: top = $urandom_range(0, ocean);
        3: top = ocean + $urandom_range(0, 5000);
        default: begin
          ocean = $urandom_range(0, 100);
          top = 65535 - $urandom_range(0, 100);
        end
      endcase
      if (top > 65535) top = 65535;
      set_ramp(top[15:0], ocean[15:0]);
      // Alternate between no idling, one-sided idling and both sides idling.
      src_gap_max  = (p % 4 == 1 || p % 4 == 3) ? 19 : 0;
      sink_gap_max = (p % 4 == 2 || p % 4 == 3) ? 19 : 0;
      span_i = int'(ramp_span());
      for (int i = 0; i < per_phase; i++) begin
        pick = $urandom_range(0, 9);
        if (pick < 7)
          height = $urandom_range(0, span_i > 65535 ? 65535 : span_i);
        else if (pick == 7)
          height = span_i - 2 + $urandom_range(0, 4);
        else
          height = $urandom_range(0, 65535);
        if (height < 0) height = 0;
        if (height > 65535) height = 65535;
        send_height(height[15:0]);
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_TOP_HEIGHT;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    top_h         = 16'd255;
    ocean_h       = 16'd0;
    src_gap_max   = 0;
    sink_gap_max  = 0;
    sink_hold     = 0;
    heights_sent  = 0;
    colors_checked = 0;
    ramps_tried   = 1;
    mismatches    = 0;
    unexpected    = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_ramp();
    test_config_extremes();
    test_random_ramps(20, 100);

    drain_colors();
    repeat (30) @(posedge clk);
    $display("Sent %0d heights over %0d ramp settings, checked %0d colors.",
             heights_sent, ramps_tried, colors_checked);
    $display("Mismatched colors: %0d, unexpected beats: %0d.", mismatches, unexpected);
    if (mismatches == 0 && unexpected == 0 && expected_colors.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/hcr_pkg.sv
sv/hcr_bounds.sv
sv/hcr_front.sv
sv/hcr_queue.sv
sv/hcr_back.sv
sv/height_color_ramp.sv
bench/tb.sv
